// ===== sv/complex_fir_decimator_defines.svh =====
// Assertion macros shared by the complex FIR decimator RTL.
// Each macro expects clk_i and rst_ni to be in scope at the point of use.
`ifndef COMPLEX_FIR_DECIMATOR_DEFINES_SVH
`define COMPLEX_FIR_DECIMATOR_DEFINES_SVH

// Checked only outside reset.
`define CFD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define CFD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== sv/cfd_pkg.sv =====
// Package for the complex FIR decimator: defaults, fixed formats, the
// stage control struct and the elaboration-time tap generator. No dependencies.
`default_nettype none

package cfd_pkg;

  // Defaults for the top-level parameters
  localparam int RATIO_DFLT       = 4;
  localparam int HALF_TAPS_DFLT   = 16;
  localparam int SAMPLE_BITS_DFLT = 16;

  // Tap format is Q1.17; output is the accumulator scaled down by 2^17
  localparam int COEF_W    = 18;
  localparam int OUT_SHIFT = 17;

  // Result buffer depth (power of two)
  localparam int RES_DEPTH = 8;

  // Fixed-point constants for the tap generator
  localparam longint          Q30_ONE    = 64'sd1073741824;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint          PI_Q26     = 64'sd210828714;
  localparam longint          COEF_MAX   = 64'sd131071;
  localparam longint          COEF_MIN   = -64'sd131072;

  // Control carried along the pipeline with each sample beat
  typedef struct packed {
    logic valid;
    logic start;
    logic emit;
  } cfd_ctl_t;

  // Unsigned 64-bit quotient by shift-subtract (elaboration only)
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Signed quotient truncated toward zero
  function automatic longint sdiv64(input longint a, input longint b);
    longint unsigned am;
    longint unsigned bm;
    longint unsigned q;
    am = $unsigned((a < 0) ? -a : a);
    bm = $unsigned((b < 0) ? -b : b);
    q  = udiv64(am, bm);
    return ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
  endfunction

  // Sine of num/den turns in Q30, degree-15 Taylor series on a reduced angle
  function automatic longint sin_q30(input longint num, input longint den);
    longint unsigned am;
    longint unsigned rem;
    longint unsigned r;
    longint unsigned p;
    longint unsigned mag;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          t;
    longint          sum;
    am  = $unsigned((num < 0) ? -num : num);
    rem = am - udiv64(am, $unsigned(den)) * $unsigned(den);
    r   = ((num < 0) && (rem != 0)) ? $unsigned(den) - rem : rem;
    p   = udiv64(r << 32, $unsigned(den));
    if (p < (64'd1 << 30)) begin
      t = $signed(p);
    end else if (p < (64'd3 << 30)) begin
      t = (64'sd1 <<< 31) - $signed(p);
    end else begin
      t = $signed(p) - (64'sd1 <<< 32);
    end
    mag  = $unsigned((t < 0) ? -t : t);
    x    = (mag * TWO_PI_Q30) >> 32;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 7; k++) begin
      term = udiv64((term * x2) >> 30, 64'(2 * k * (2 * k + 1)));
      sum  = k[0] ? sum - $signed(term) : sum + $signed(term);
    end
    return (t < 0) ? -sum : sum;
  endfunction

  // Blackman-windowed sinc tap idx, scaled by 1/ratio, rounded into Q1.17
  function automatic logic signed [COEF_W-1:0] tap_coef(input int idx,
                                                        input int ratio,
                                                        input int half_taps);
    longint          ratio_l;
    longint          half_l;
    longint          idx_l;
    longint          m;
    longint          sinc;
    longint          c1;
    longint          c2;
    longint          w;
    longint          prod;
    longint          c;
    longint unsigned mag;
    longint unsigned dv;
    longint unsigned q;
    ratio_l = ratio;
    half_l  = half_taps;
    idx_l   = idx;
    m       = idx_l - half_l;
    if (m == 0) begin
      sinc = Q30_ONE;
    end else begin
      sinc = sdiv64(sin_q30(m, 2 * ratio_l) * ratio_l * (64'sd1 <<< 26), PI_Q26 * m);
    end
    c1   = sin_q30(idx_l * 4 + 2 * half_l, 8 * half_l);
    c2   = sin_q30(idx_l * 4 + half_l, 4 * half_l);
    w    = sdiv64(42 * Q30_ONE - 50 * c1 + 8 * c2, 64'sd100);
    prod = sinc * w;
    mag  = $unsigned((prod < 0) ? -prod : prod);
    dv   = $unsigned(ratio_l) << 43;
    q    = udiv64(mag + (dv >> 1), dv);
    c    = (prod < 0) ? -$signed(q) : $signed(q);
    if (c > COEF_MAX) begin
      c = COEF_MAX;
    end
    if (c < COEF_MIN) begin
      c = COEF_MIN;
    end
    return c[COEF_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/cfd_seq_ctrl.sv =====
// Input sequencing for the complex FIR decimator: warmup and decimation
// counters, emit decision and output credit. Depends on cfd_pkg and the defines header.
`default_nettype none
`include "complex_fir_decimator_defines.svh"

module cfd_seq_ctrl #(
  parameter int RATIO     = cfd_pkg::RATIO_DFLT,
  parameter int HALF_TAPS = cfd_pkg::HALF_TAPS_DFLT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              start_req_i,
  input  wire logic              out_fire_i,
  output logic                   in_ready_o,
  output cfd_pkg::cfd_ctl_t      ctl_o
);

  localparam int WARM_W   = $clog2(HALF_TAPS + 1);
  localparam int PHASE_W  = (RATIO > 1) ? $clog2(RATIO) : 1;
  localparam int CREDIT_W = $clog2(cfd_pkg::RES_DEPTH + 1);

  logic [WARM_W-1:0]   warm_q, warm_d, warm_cur;
  logic [PHASE_W-1:0]  phase_q, phase_d, phase_cur;
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic                accept;
  logic                emit;
  cfd_pkg::cfd_ctl_t   ctl_q, ctl_d;

  // Ready while the result buffer can still hold every result in flight
  assign in_ready_o = (credit_q < CREDIT_W'(cfd_pkg::RES_DEPTH));
  assign accept     = in_valid_i & in_ready_o;

  // Counters; a start beat sees them cleared
  always_comb begin
    warm_cur  = start_req_i ? '0 : warm_q;
    phase_cur = start_req_i ? '0 : phase_q;
    warm_d    = warm_q;
    phase_d   = phase_q;
    emit      = 1'b0;
    if (accept) begin
      if (warm_cur < WARM_W'(HALF_TAPS)) begin
        warm_d  = warm_cur + 1'b1;
        phase_d = phase_cur;
      end else begin
        warm_d  = warm_cur;
        emit    = (phase_cur == '0);
        phase_d = (phase_cur == PHASE_W'(RATIO - 1)) ? '0 : phase_cur + 1'b1;
      end
    end
  end

  // Credit: one per emitted result until its output beat leaves
  always_comb begin
    credit_d = credit_q;
    case ({accept & emit, out_fire_i})
      2'b10:   credit_d = credit_q + 1'b1;
      2'b01:   credit_d = credit_q - 1'b1;
      default: credit_d = credit_q;
    endcase
  end

  always_comb begin
    ctl_d       = '0;
    ctl_d.valid = accept;
    ctl_d.start = start_req_i;
    ctl_d.emit  = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q   <= '0;
      phase_q  <= '0;
      credit_q <= '0;
      ctl_q    <= '0;
    end else begin
      warm_q   <= warm_d;
      phase_q  <= phase_d;
      credit_q <= credit_d;
      ctl_q    <= ctl_d;
    end
  end

  assign ctl_o = ctl_q;

  `CFD_ASSERT(a_credit_bound, credit_q <= CREDIT_W'(cfd_pkg::RES_DEPTH), "credit overrun")
  `CFD_ASSERT(a_credit_drop, (credit_q < $past(credit_q)) |-> $past(out_fire_i), "credit lost without output beat")

endmodule

`default_nettype wire

// ===== sv/cfd_tap_cell.sv =====
// One cell of the transposed FIR chain: registered tap product and the
// partial sum handed to the next cell toward the output. Depends on cfd_pkg.
`default_nettype none

module cfd_tap_cell #(
  parameter int                                  SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DFLT,
  parameter int                                  ACC_W       = 40,
  parameter logic signed [cfd_pkg::COEF_W-1:0]   COEF        = '0
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire cfd_pkg::cfd_ctl_t              s1_i,
  input  wire cfd_pkg::cfd_ctl_t              s2_i,
  input  wire logic signed [SAMPLE_BITS-1:0]  x_re_i,
  input  wire logic signed [SAMPLE_BITS-1:0]  x_im_i,
  input  wire logic signed [ACC_W-1:0]        sum_re_i,
  input  wire logic signed [ACC_W-1:0]        sum_im_i,
  output logic signed [ACC_W-1:0]             sum_re_o,
  output logic signed [ACC_W-1:0]             sum_im_o
);

  localparam int PROD_W = SAMPLE_BITS + cfd_pkg::COEF_W;

  logic signed [PROD_W-1:0] p_re_q, p_im_q;
  logic signed [ACC_W-1:0]  s_re_q, s_im_q, s_re_d, s_im_d;
  logic signed [ACC_W-1:0]  carry_re, carry_im;

  // Tap product of the current sample
  always_ff @(posedge clk_i) begin
    if (s1_i.valid) begin
      p_re_q <= PROD_W'(x_re_i) * PROD_W'(COEF);
      p_im_q <= PROD_W'(x_im_i) * PROD_W'(COEF);
    end
  end

  // Partial sum; a start beat drops the older history
  always_comb begin
    carry_re = s2_i.start ? '0 : sum_re_i;
    carry_im = s2_i.start ? '0 : sum_im_i;
    s_re_d   = ACC_W'(p_re_q) + carry_re;
    s_im_d   = ACC_W'(p_im_q) + carry_im;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_re_q <= '0;
      s_im_q <= '0;
    end else if (s2_i.valid) begin
      s_re_q <= s_re_d;
      s_im_q <= s_im_d;
    end
  end

  assign sum_re_o = s_re_q;
  assign sum_im_o = s_im_q;

endmodule

`default_nettype wire

// ===== sv/cfd_out_stage.sv =====
// Output stage of the complex FIR decimator: rounding, saturation and a
// small result buffer toward the output channel. Depends on cfd_pkg and the defines header.
`default_nettype none
`include "complex_fir_decimator_defines.svh"

module cfd_out_stage #(
  parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DFLT,
  parameter int ACC_W       = 40
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire cfd_pkg::cfd_ctl_t          ctl_i,
  input  wire logic signed [ACC_W-1:0]    acc_re_i,
  input  wire logic signed [ACC_W-1:0]    acc_im_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]   out_re_o,
  output logic signed [SAMPLE_BITS-1:0]   out_im_o,
  output logic                            saturated_o
);

  localparam int RND_W = ACC_W + 1;
  localparam int SCL_W = RND_W - cfd_pkg::OUT_SHIFT;
  localparam int DEPTH = cfd_pkg::RES_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (cfd_pkg::OUT_SHIFT - 1);
  localparam logic signed [SCL_W-1:0] OUT_MAX  =
    {{(SCL_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SCL_W-1:0] OUT_MIN  =
    {{(SCL_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  // Clip a scaled value; top bit of the result flags clipping
  function automatic logic [SAMPLE_BITS:0] clip_fn(input logic signed [SCL_W-1:0] v);
    logic                          clipped;
    logic signed [SCL_W-1:0]       r;
    clipped = 1'b0;
    r       = v;
    if (v > OUT_MAX) begin
      r       = OUT_MAX;
      clipped = 1'b1;
    end
    if (v < OUT_MIN) begin
      r       = OUT_MIN;
      clipped = 1'b1;
    end
    return {clipped, r[SAMPLE_BITS-1:0]};
  endfunction

  logic signed [RND_W-1:0]       rnd_re, rnd_im;
  logic signed [SCL_W-1:0]       scl_re, scl_im;
  logic [SAMPLE_BITS:0]          cl_re, cl_im;
  logic                          push, pop;

  logic signed [SAMPLE_BITS-1:0] re_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] im_mem [DEPTH];
  logic                          sat_mem [DEPTH];
  logic [PTR_W-1:0]              wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]              count_q, count_d;

  // Round half up, drop 17 fraction bits, clip
  always_comb begin
    rnd_re = RND_W'(acc_re_i) + RND_HALF;
    rnd_im = RND_W'(acc_im_i) + RND_HALF;
    scl_re = rnd_re[RND_W-1:cfd_pkg::OUT_SHIFT];
    scl_im = rnd_im[RND_W-1:cfd_pkg::OUT_SHIFT];
    cl_re  = clip_fn(scl_re);
    cl_im  = clip_fn(scl_im);
  end

  assign push        = ctl_i.valid & ctl_i.emit;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o & out_ready_i;

  // Result buffer storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      re_mem[wr_ptr_q]  <= cl_re[SAMPLE_BITS-1:0];
      im_mem[wr_ptr_q]  <= cl_im[SAMPLE_BITS-1:0];
      sat_mem[wr_ptr_q] <= cl_re[SAMPLE_BITS] | cl_im[SAMPLE_BITS];
    end
  end

  always_comb begin
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  assign out_re_o    = re_mem[rd_ptr_q];
  assign out_im_o    = im_mem[rd_ptr_q];
  assign saturated_o = sat_mem[rd_ptr_q];

  `CFD_ASSERT(a_no_overflow, push |-> (count_q < CNT_W'(DEPTH)) || pop, "result buffer overflow")
  `CFD_ASSERT(a_pop_count, (pop && !push) |=> (count_q == $past(count_q) - 1'b1), "count off after pop")

endmodule

`default_nettype wire

// ===== sv/complex_fir_decimator.sv =====
// Complex FIR decimator, top level (uses cfd_pkg, cfd_seq_ctrl, cfd_tap_cell,
// cfd_out_stage). Low-pass filters complex samples with a real Blackman-windowed
// sinc of 2*HALF_TAPS taps and keeps every RATIO-th output after HALF_TAPS samples.
// Input channel: one complex sample per beat, with start_req_i set on the first
// beat of a new stream to clear the delay line and counters.
// Output channel: one rounded, saturated complex result per beat; saturated_o
// marks a clipped part.
// Throughput: one sample per clock unless stalled. Every sample moves the
// transposed tap chain one step; each cell owns a tap product and a partial sum.
// Path: a result passes the input register, the tap product, the partial sum
// and the result buffer, in that order, before it reaches the output.
// Stall: results queue in an 8-entry buffer; in_ready_o drops once 8 results
// are pending between the input and the output, so nothing is dropped.
// Reset: asynchronous, active low; clears the counters and delay line as a start
// beat does and also empties the result buffer. No clearing pass is needed.
`default_nettype none

module complex_fir_decimator #(
  parameter int RATIO       = cfd_pkg::RATIO_DFLT,
  parameter int HALF_TAPS   = cfd_pkg::HALF_TAPS_DFLT,
  parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DFLT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]  sample_re_i,
  input  wire logic signed [SAMPLE_BITS-1:0]  sample_im_i,
  input  wire logic                           start_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       out_re_o,
  output logic signed [SAMPLE_BITS-1:0]       out_im_o,
  output logic                                saturated_o
);

  localparam int TAPS  = 2 * HALF_TAPS;
  localparam int ACC_W = SAMPLE_BITS + cfd_pkg::COEF_W + $clog2(TAPS);

  cfd_pkg::cfd_ctl_t             ctl_s1, ctl_s2_q, ctl_s3_q;
  logic signed [SAMPLE_BITS-1:0] x_re_q, x_im_q;
  logic signed [ACC_W-1:0]       chain_re [TAPS+1];
  logic signed [ACC_W-1:0]       chain_im [TAPS+1];
  logic                          in_accept;
  logic                          out_fire;

  assign in_accept = in_valid_i & in_ready_o;
  assign out_fire  = out_valid_o & out_ready_i;

  // Counters and flow control
  cfd_seq_ctrl #(
    .RATIO     (RATIO),
    .HALF_TAPS (HALF_TAPS)
  ) u_seq_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .start_req_i (start_req_i),
    .out_fire_i  (out_fire),
    .in_ready_o  (in_ready_o),
    .ctl_o       (ctl_s1)
  );

  // Input sample register, aligned with ctl_s1
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_re_q <= sample_re_i;
      x_im_q <= sample_im_i;
    end
  end

  // Control follows the sample down the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_s2_q <= '0;
      ctl_s3_q <= '0;
    end else begin
      ctl_s2_q <= ctl_s1;
      ctl_s3_q <= ctl_s2_q;
    end
  end

  // Transposed chain: sums run from the last cell toward cell 0
  assign chain_re[TAPS] = '0;
  assign chain_im[TAPS] = '0;

  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    localparam logic signed [cfd_pkg::COEF_W-1:0] COEF_K =
      cfd_pkg::tap_coef(k, RATIO, HALF_TAPS);

    cfd_tap_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_W       (ACC_W),
      .COEF        (COEF_K)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .s1_i     (ctl_s1),
      .s2_i     (ctl_s2_q),
      .x_re_i   (x_re_q),
      .x_im_i   (x_im_q),
      .sum_re_i (chain_re[k+1]),
      .sum_im_i (chain_im[k+1]),
      .sum_re_o (chain_re[k]),
      .sum_im_o (chain_im[k])
    );
  end

  // Cell 0 holds the filter output
  cfd_out_stage #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_W       (ACC_W)
  ) u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl_s3_q),
    .acc_re_i    (chain_re[0]),
    .acc_im_i    (chain_im[0]),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .saturated_o (saturated_o)
  );

endmodule

`default_nettype wire
